// File: rtl/core/dspe_pkg.sv
// ----------------------------------------------------------------------------
// Dense shortest path engine package
// Shared constants, codes and the node record kept in the node state memory.
// ----------------------------------------------------------------------------
package dspe_pkg;

   localparam int DEF_MAX_NODES   = 16;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int NODE_FIELD_W   = 6;
   localparam int WEIGHT_FIELD_W = 17;
   localparam int DIST_W         = 22;
   localparam int COUNT_W        = 7;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 40;
   localparam int LIN_W          = 13;

   localparam logic [DIST_W-1:0]  DIST_MAX         = {DIST_W{1'b1}};
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd16;

   // Operation codes carried on the input channel's tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   // Register index, taken from csr_paddr[2].
   localparam logic REG_NODE_COUNT = 1'b0;

   typedef struct packed {
      logic [DIST_W-1:0]       path_cost;
      logic                    reached;
      logic                    visited;
      logic [NODE_FIELD_W-1:0] parent;
      logic                    has_parent;
   } node_rec_type;

endpackage

// File: rtl/core/dspe_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dspe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/dense_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// Dense shortest path engine
// Single-source shortest paths from node 0 over an adjacency matrix memory.
// ----------------------------------------------------------------------------
// Usage: the req channel carries two kinds of item, chosen by req_tuser. A
// write item stores one edge weight in the matrix memory; writes may follow
// each other in every cycle. A run item starts a search over the first
// node_count nodes (set through the csr port while idle) and yields one rsp
// item per node, in node order, tlast on the final one. A run with n nodes
// first clears n node records, then does up to n-1 rounds, each a scan of
// the node memory for the nearest open node, a mark step and a relax pass
// over one matrix row. Results then leave one at a time; the next node
// record is read only after the previous item is taken. The loops are set
// by the single read port of each memory, one node or one weight per cycle.
// req_tready is high only while the engine is idle; a stalled receiver holds
// the engine in its output state with the result item steady. Reset returns
// to idle, drops rsp_tvalid and sets node_count to sixteen; the matrix memory
// is not cleared, and each run clears its own node records.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine #(
   parameter int MAX_NODES   = dspe_pkg::DEF_MAX_NODES,
   parameter int WEIGHT_BITS = dspe_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: from_node[5:0], to_node[11:6], edge_weight[28:12], zero fill
   input  logic [dspe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: op
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: node[5:0], distance[27:6], reachable[28], predecessor[34:29],
   // has_predecessor[35], zero fill
   output logic [dspe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dspe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dspe_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dspe_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import dspe_pkg::*;

   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);
   localparam int WVAL_W    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
   localparam int WMAT_W    = WVAL_W + 1;
   localparam logic [15:0] WCAP = 16'((32'd1 << WVAL_W) - 32'd1);
   localparam int REC_W     = $bits(node_rec_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_PICK,
      S_MARK,
      S_RELAX,
      S_OUT_RD,
      S_OUT_LD,
      S_OUT_WAIT
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      node_count_ff, node_count_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic [CNT_W-1:0]        round_ff, round_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [NODE_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                    best_found_ff, best_found_in;
   logic [NODE_W-1:0]       best_idx_ff, best_idx_in;
   node_rec_type            best_rec_ff, best_rec_in;
   logic [LIN_W-1:0]        row_base_ff, row_base_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    nr_we;
   logic [NODE_W-1:0]       nr_waddr;
   node_rec_type            nr_wdata;
   logic [NODE_W-1:0]       nr_raddr;
   logic [REC_W-1:0]        nr_rdata_raw;
   node_rec_type            nr_rdata;
   logic                    wm_we;
   logic [MAT_AW-1:0]       wm_waddr;
   logic [WMAT_W-1:0]       wm_wdata;
   logic [MAT_AW-1:0]       wm_raddr;
   logic [WMAT_W-1:0]       wm_rdata;

   logic [NODE_FIELD_W-1:0]   in_from;
   logic [NODE_FIELD_W-1:0]   in_to;
   logic [WEIGHT_FIELD_W-1:0] in_weight;
   logic                      in_range;
   logic [LIN_W-1:0]          wr_lin;
   logic [LIN_W-1:0]          rel_lin;
   logic [15:0]               wr_capped;
   logic [CNT_W-1:0]          n_act;
   logic [CNT_W-1:0]          n_last;
   logic [DIST_W:0]           path_sum;
   logic [DIST_W-1:0]         cand;
   logic                      csr_write;

   assign in_from   = req_tdata[5:0];
   assign in_to     = req_tdata[11:6];
   assign in_weight = req_tdata[28:12];
   assign in_range  = ({1'b0, in_from} < 7'(MAX_NODES)) && ({1'b0, in_to} < 7'(MAX_NODES));
   assign wr_lin    = LIN_W'(in_from) * LIN_W'(MAX_NODES) + LIN_W'(in_to);
   assign wr_capped = (in_weight[15:0] > WCAP) ? WCAP : in_weight[15:0];
   assign rel_lin   = row_base_ff + LIN_W'(scan_ff);

   // Out-of-range node counts fold into the range one to MAX_NODES.
   assign n_act = (node_count_ff == '0) ? CNT_W'(1) :
                  (node_count_ff > 7'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                  CNT_W'(node_count_ff);
   assign n_last = n_ff - CNT_W'(1);

   assign nr_rdata = node_rec_type'(nr_rdata_raw);
   assign path_sum = {1'b0, best_rec_ff.path_cost} + (DIST_W + 1)'(wm_rdata[WVAL_W-1:0]);
   assign cand     = path_sum[DIST_W] ? DIST_MAX : path_sum[DIST_W-1:0];

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      n_in          = n_ff;
      scan_in       = scan_ff;
      round_in      = round_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_ff[NODE_W-1:0];
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_rec_in   = best_rec_ff;
      row_base_in   = row_base_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      nr_we    = 1'b0;
      nr_waddr = rd_idx_ff;
      nr_wdata = nr_rdata;
      nr_raddr = scan_ff[NODE_W-1:0];
      wm_we    = 1'b0;
      wm_waddr = wr_lin[MAT_AW-1:0];
      wm_wdata = {in_weight[16], wr_capped[WVAL_W-1:0]};
      wm_raddr = rel_lin[MAT_AW-1:0];

      if (csr_write && (csr_paddr[2] == REG_NODE_COUNT)) begin
         node_count_in = csr_pwdata[COUNT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_RUN) begin
                  n_in     = n_act;
                  scan_in  = '0;
                  round_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  wm_we = in_range;
               end
            end
         end
         S_CLEAR: begin
            nr_we            = 1'b1;
            nr_waddr         = scan_ff[NODE_W-1:0];
            nr_wdata         = '0;
            nr_wdata.reached = (scan_ff == '0);
            if (scan_ff == n_last) begin
               scan_in       = '0;
               best_found_in = 1'b0;
               state_in      = (n_ff == CNT_W'(1)) ? S_OUT_RD : S_PICK;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         S_PICK: begin
            if (scan_ff != n_ff) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
            end
            // Strict compare keeps the lowest index on equal distances.
            if (rd_vld_ff && !nr_rdata.visited && nr_rdata.reached &&
                (!best_found_ff || (nr_rdata.path_cost < best_rec_ff.path_cost))) begin
               best_found_in = 1'b1;
               best_idx_in   = rd_idx_ff;
               best_rec_in   = nr_rdata;
            end
            if ((scan_ff == n_ff) && !rd_vld_ff) begin
               scan_in = '0;
               if (best_found_ff) begin
                  row_base_in = LIN_W'(best_idx_ff) * LIN_W'(MAX_NODES);
                  state_in    = S_MARK;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         S_MARK: begin
            nr_we            = 1'b1;
            nr_waddr         = best_idx_ff;
            nr_wdata         = best_rec_ff;
            nr_wdata.visited = 1'b1;
            scan_in          = '0;
            state_in         = S_RELAX;
         end
         S_RELAX: begin
            if (scan_ff != n_ff) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
            end
            // The write lands one entry behind the read, so no entry is read
            // while its update is still in flight.
            if (rd_vld_ff && !wm_rdata[WVAL_W] && !nr_rdata.visited &&
                (!nr_rdata.reached || (nr_rdata.path_cost > cand))) begin
               nr_we               = 1'b1;
               nr_wdata.path_cost  = cand;
               nr_wdata.reached    = 1'b1;
               nr_wdata.parent     = NODE_FIELD_W'(best_idx_ff);
               nr_wdata.has_parent = 1'b1;
            end
            if ((scan_ff == n_ff) && !rd_vld_ff) begin
               scan_in       = '0;
               best_found_in = 1'b0;
               round_in      = round_ff + CNT_W'(1);
               state_in      = ((round_ff + CNT_W'(1)) == n_last) ? S_OUT_RD : S_PICK;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_data_in = {4'b0000,
                           nr_rdata.has_parent,
                           nr_rdata.has_parent ? nr_rdata.parent : '0,
                           nr_rdata.reached,
                           nr_rdata.reached ? nr_rdata.path_cost : '0,
                           NODE_FIELD_W'(scan_ff)};
            rsp_last_in  = (scan_ff == n_last);
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in  = scan_ff + CNT_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         n_ff          <= CNT_W'(1);
         scan_ff       <= '0;
         round_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         n_ff          <= n_in;
         scan_ff       <= scan_in;
         round_ff      <= round_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      row_base_ff <= row_base_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   dspe_ram #(
      .WIDTH (WMAT_W),
      .DEPTH (MAT_DEPTH)
   ) u_weight_ram (
      .clock (clock),
      .we    (wm_we),
      .waddr (wm_waddr),
      .wdata (wm_wdata),
      .raddr (wm_raddr),
      .rdata (wm_rdata)
   );

   dspe_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (nr_we),
      .waddr (nr_waddr),
      .wdata (REC_W'(nr_wdata)),
      .raddr (nr_raddr),
      .rdata (nr_rdata_raw)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NODE_COUNT) ?
                       CSR_DATA_W'(node_count_ff) : '0;

   a_not_both_sides: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   a_relax_skips_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RELAX && nr_we) |-> (nr_waddr != best_idx_ff))
      else $error("relax pass updated the node it expands");

   a_mark_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> best_found_ff)
      else $error("mark without a picked node");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff < n_ff)
      else $error("round count reached the node count");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == S_IDLE))
      else $error("engine did not return to idle after the last result");

endmodule
